// ===== hw/rtl/lmcd_pkg.sv =====
// Shared types, constants and the digit segment table for the LCD clock driver.
// No dependencies; used by lmcd_tick and lcd_mux_clock_driver_top.
package lmcd_pkg;

    localparam int DIGIT_COUNT       = 4;
    localparam int BYTE_COUNT        = DIGIT_COUNT + 1;
    localparam int HALF_SECOND_TICKS = 125;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_LOAD_CLOCK = 2'd1;
    localparam logic [1:0] CMD_LOAD_ALARM = 2'd2;

    localparam logic [7:0] MARK_BIT     = 8'h80;
    localparam logic [7:0] P_FIRST      = 8'h10;
    localparam logic [7:0] P_RESET      = 8'h08;
    localparam logic [7:0] IND_CHOOSE   = 8'h0F;
    localparam logic [7:0] IND_HOUR     = 8'h03;
    localparam logic [7:0] IND_MINUTE   = 8'h0C;
    localparam logic [4:0] ALARM_HOUR_RESET = 5'd12;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic       adjust_mode;
        logic       alarm_shown;
        logic [1:0] adjust_stage;
    } in_t;

    typedef struct packed {
        logic [8:0] seg_bits;
        logic [1:0] active_com;
        logic       com_level;
        logic       alarm_match;
        logic [4:0] hour;
        logic [5:0] minute;
    } out_t;

    typedef struct packed {
        logic [BYTE_COUNT-1:0][7:0]  disp;
        logic [DIGIT_COUNT-1:0][3:0] digit;
        logic [2:0]                  phase;
        logic                        half_flag;
        logic                        sec_toggle;
        logic [5:0]                  seconds;
        logic [4:0]                  clock_hour;
        logic [5:0]                  clock_minute;
        logic [4:0]                  alarm_hour;
        logic [5:0]                  alarm_minute;
    } state_t;

    function automatic state_t state_reset();
        state_t s;
        s              = '0;
        s.disp[BYTE_COUNT-1] = P_RESET;
        s.alarm_hour   = ALARM_HOUR_RESET;
        return s;
    endfunction

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'h0: p = 8'h7B;
            4'h1: p = 8'h30;
            4'h2: p = 8'h5D;
            4'h3: p = 8'h75;
            4'h4: p = 8'h36;
            4'h5: p = 8'h67;
            4'h6: p = 8'h6F;
            4'h7: p = 8'h31;
            4'h8: p = 8'h7F;
            4'h9: p = 8'h77;
            4'hA: p = 8'h3F;
            4'hB: p = 8'h6E;
            4'hC: p = 8'h4C;
            4'hD: p = 8'h7C;
            4'hE: p = 8'h4F;
            default: p = 8'h0F;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/lmcd_tick.sv =====
// Next-state and result logic for one transaction of the LCD clock driver.
// Depends on lmcd_pkg.
module lmcd_tick (
    input  lmcd_pkg::state_t st,
    input  lmcd_pkg::in_t    din,
    input  logic             half_tick,
    output lmcd_pkg::state_t st_next,
    output lmcd_pkg::out_t   res
);

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] r;
        r = v - 6'({3'd0, t} * 6'd10);
        return r[3:0];
    endfunction

    function automatic logic [7:0] rot_r(input logic [7:0] b);
        return {b[0], b[7:1]};
    endfunction

    logic [lmcd_pkg::BYTE_COUNT-1:0][7:0] b;
    logic [8:0]                            segs;
    logic [4:0]                            ld_h;
    logic [5:0]                            ld_m;
    logic [5:0]                            show_h;
    logic [5:0]                            show_m;
    logic [2:0]                            th;
    logic [2:0]                            tm;

    always_comb begin
        st_next = st;
        b       = st.disp;
        segs    = '0;
        show_h  = '0;
        show_m  = '0;
        th      = '0;
        tm      = '0;
        ld_h    = (din.new_hour < 5'd24) ? din.new_hour : 5'd0;
        ld_m    = (din.new_minute < 6'd60) ? din.new_minute : 6'd0;

        case (din.command)
            lmcd_pkg::CMD_LOAD_CLOCK: begin
                st_next.clock_hour   = ld_h;
                st_next.clock_minute = ld_m;
            end
            lmcd_pkg::CMD_LOAD_ALARM: begin
                st_next.alarm_hour   = ld_h;
                st_next.alarm_minute = ld_m;
            end
            lmcd_pkg::CMD_TICK: begin
                if (st.phase == 3'd0) begin
                    for (int i = 0; i < lmcd_pkg::DIGIT_COUNT; i++) begin
                        b[i] = (b[i] & lmcd_pkg::MARK_BIT) | lmcd_pkg::seg_pattern(st.digit[i]);
                    end
                end else begin
                    for (int i = 0; i < lmcd_pkg::BYTE_COUNT; i++) begin
                        if (!st.phase[0]) begin
                            b[i] = rot_r(b[i]);
                        end
                        b[i] = ~b[i];
                    end
                end

                for (int i = 0; i < 4; i++) begin
                    segs[2*i]   = b[i][0];
                    segs[2*i+1] = b[i][4];
                end
                segs[8] = b[4][0];

                if (st.phase == 3'd0) begin
                    if (st.half_flag) begin
                        b[0] = b[0] ^ lmcd_pkg::MARK_BIT;
                        st_next.sec_toggle = !st.sec_toggle;
                        if (st.sec_toggle) begin
                            b[1] = b[1] & ~lmcd_pkg::MARK_BIT;
                            b[4] = b[4][0] ? lmcd_pkg::P_FIRST : rot_r(b[4]);
                            if (st.seconds == 6'd59) begin
                                st_next.seconds = '0;
                                if (st.clock_minute == 6'd59) begin
                                    st_next.clock_minute = '0;
                                    st_next.clock_hour = (st.clock_hour == 5'd23) ?
                                        5'd0 : st.clock_hour + 5'd1;
                                end else begin
                                    st_next.clock_minute = st.clock_minute + 6'd1;
                                end
                            end else begin
                                st_next.seconds = st.seconds + 6'd1;
                            end
                        end
                    end
                    if (din.adjust_mode) begin
                        if (din.alarm_shown) begin
                            b[1] = b[1] | lmcd_pkg::MARK_BIT;
                        end else begin
                            b[1] = b[1] & ~lmcd_pkg::MARK_BIT;
                        end
                        if (din.adjust_stage == 2'd0) begin
                            b[4] = lmcd_pkg::IND_CHOOSE;
                        end else if (din.adjust_stage[1]) begin
                            b[4] = lmcd_pkg::IND_MINUTE;
                        end else begin
                            b[4] = lmcd_pkg::IND_HOUR;
                        end
                    end
                    if (din.adjust_mode && din.alarm_shown) begin
                        show_h = {1'b0, st_next.alarm_hour};
                        show_m = st_next.alarm_minute;
                    end else begin
                        show_h = {1'b0, st_next.clock_hour};
                        show_m = st_next.clock_minute;
                    end
                    th = tens_of(show_h);
                    tm = tens_of(show_m);
                    st_next.digit[0] = {1'b0, th};
                    st_next.digit[1] = ones_of(show_h, th);
                    st_next.digit[2] = {1'b0, tm};
                    st_next.digit[3] = ones_of(show_m, tm);
                    st_next.half_flag = 1'b0;
                    st_next.phase = 3'd1;
                end else if (st.phase == 3'd7) begin
                    for (int i = 0; i < lmcd_pkg::BYTE_COUNT; i++) begin
                        b[i] = rot_r(b[i]);
                        b[i] = ~{b[i][3:0], b[i][7:4]};
                    end
                    st_next.phase = 3'd0;
                end else begin
                    st_next.phase = st.phase + 3'd1;
                end

                if (half_tick) begin
                    st_next.half_flag = 1'b1;
                end
                st_next.disp = b;
            end
            default: begin
            end
        endcase

        res.seg_bits    = segs;
        res.active_com  = st.phase[2:1];
        res.com_level   = st.phase[0];
        res.alarm_match = (st_next.clock_hour == st_next.alarm_hour) &&
                          (st_next.clock_minute == st_next.alarm_minute);
        res.hour        = st_next.clock_hour;
        res.minute      = st_next.clock_minute;
    end

endmodule

// ===== hw/rtl/lcd_mux_clock_driver_top.sv =====
// Quarter-duty, half-bias multiplexed LCD driver with 24-hour clock and alarm.
// A tick transaction's result is registered and appears in the cycle after acceptance.
// Throughput: one transaction per cycle; the output register lets a new
// transaction in whenever the result slot is empty or being taken.
// Load commands update the time registers and give no result.
// Reset (aresetn low, synchronous): phase 0, display cleared with P4 lit, alarm 12:00.
module lcd_mux_clock_driver_top #(
    parameter int HALF_SECOND_TICKS = lmcd_pkg::HALF_SECOND_TICKS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lmcd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output lmcd_pkg::out_t m_data
);

    localparam int CD_W = $clog2(HALF_SECOND_TICKS + 1);

    lmcd_pkg::state_t st_reg;
    lmcd_pkg::state_t st_next;
    logic [CD_W-1:0]  cd_reg;
    logic [CD_W-1:0]  cd_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    lmcd_pkg::out_t   m_data_reg;
    lmcd_pkg::out_t   res;
    logic             accept;
    logic             is_tick;
    logic             half_tick;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_tick   = (s_data.command == lmcd_pkg::CMD_TICK);
    assign half_tick = (cd_reg == CD_W'(1));

    lmcd_tick u_tick (
        .st        (st_reg),
        .din       (s_data),
        .half_tick (half_tick),
        .st_next   (st_next),
        .res       (res)
    );

    always_comb begin
        cd_next = cd_reg;
        if (accept && is_tick) begin
            cd_next = half_tick ? CD_W'(HALF_SECOND_TICKS) : cd_reg - CD_W'(1);
        end
        if (accept) begin
            m_valid_next = is_tick;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= lmcd_pkg::state_reset();
            cd_reg      <= CD_W'(HALF_SECOND_TICKS);
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg <= st_next;
            end
            cd_reg      <= cd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_tick) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_load_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_tick |=> !m_valid)
        else $error("load transaction produced a result");

    a_tick_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_tick |=> m_valid)
        else $error("tick transaction gave no result");

    a_phase_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> st_reg.phase == 3'({m_data_reg.active_com, m_data_reg.com_level} + 3'd1))
        else $error("phase out of step with shown COM");

    a_countdown_live : assert property (@(posedge aclk) disable iff (!aresetn)
        cd_reg != '0)
        else $error("half-second countdown reached zero");
`endif

endmodule
